### rtl/alcs_pkg.sv
// ----------------------------------------------------------------------------
// Audio level color sequencer package
// Shared widths, register indexes and pattern codes for the sequencer.
// ----------------------------------------------------------------------------
package alcs_pkg;

  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned PAT_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHTNESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_CHANNEL_LEVEL = 2'd2;

  // Configuration reset values
  localparam logic [CFG_DATA_W-1:0] MIN_BRIGHTNESS_RST = 8'd90;

  // Brightness and silence thresholds
  localparam logic [COLOR_W-1:0] BRIGHT_MAX    = 8'd255;
  localparam logic [COLOR_W-1:0] LOUD_LEVEL    = 8'd100;
  localparam logic [7:0]         QUIET_RUN_MAX = 8'd10;

  // Color pattern codes (R,G,B with b = brightness, o = off level)
  localparam logic [PAT_W-1:0] PAT_BLUE    = 3'd0;  // o,o,b
  localparam logic [PAT_W-1:0] PAT_GREEN   = 3'd1;  // o,b,o
  localparam logic [PAT_W-1:0] PAT_RED     = 3'd2;  // b,o,o
  localparam logic [PAT_W-1:0] PAT_YELLOW  = 3'd3;  // b,b,o
  localparam logic [PAT_W-1:0] PAT_CYAN    = 3'd4;  // o,b,b
  localparam logic [PAT_W-1:0] PAT_MAGENTA = 3'd5;  // b,o,b
  localparam logic [PAT_W-1:0] PAT_WHITE   = 3'd6;  // b,b,b set at once
  localparam logic [PAT_W-1:0] PAT_FLASH   = 3'd7;  // b,b,b forced after silence

endpackage

### rtl/audio_level_color_sequencer_top.sv
// ----------------------------------------------------------------------------
// Audio level color sequencer
// Turns a stream of signed audio levels into RGB targets with a fade flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, level) carries one signed 16-bit audio
//   level per transaction. Output channel (out_valid/out_ready, red, green,
//   blue, fade, pattern) returns exactly one color target per input
//   transaction, in order.
//   An accepted level is held in the input register until the result
//   register is free or draining; then the color and all counters are
//   computed in one pass into the result register, which raises out_valid.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; the state update (loud ticks, pattern, peak, quiet run) is
//   computed combinationally from the input register and the state.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more level; in_ready drops once both are full.
//   The user makes configuration writes (cfg_we, cfg_index, cfg_data) while
//   the block is idle (not enforced). Unknown indexes are ignored.
//   Synchronous reset clears all counters, the peak and the pattern, and
//   loads the configuration defaults (min brightness 90, others 0).
// ----------------------------------------------------------------------------
module audio_level_color_sequencer_top
  import alcs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [LEVEL_W-1:0]    level,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COLOR_W-1:0]           red,
  output logic [COLOR_W-1:0]           green,
  output logic [COLOR_W-1:0]           blue,
  output logic                         fade,
  output logic [PAT_W-1:0]             pattern
);

  // Configuration registers
  logic [7:0] ticks_per_pattern;
  logic [7:0] min_brightness;
  logic [7:0] off_channel_level;

  // Sequencer state
  logic [PAT_W-1:0]          pattern_index, pattern_index_next;
  logic [7:0]                loud_ticks, loud_ticks_next;
  logic signed [LEVEL_W-1:0] peak_level, peak_level_next;
  logic [7:0]                peak_age, peak_age_next;
  logic [7:0]                quiet_count, quiet_count_next;

  // Input register
  logic                      s1_valid;
  logic signed [LEVEL_W-1:0] s1_level;

  // Handshake
  logic advance;
  logic in_fire;

  // Datapath
  logic [COLOR_W-1:0]        bright;
  logic [7:0]                loud_inc;
  logic signed [LEVEL_W-1:0] peak_max;
  logic signed [19:0]        lvl_x5;
  logic signed [19:0]        peak_ext;
  logic                      quiet;
  logic [COLOR_W-1:0]        red_next, green_next, blue_next;
  logic                      fade_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_pattern <= '0;
      min_brightness    <= MIN_BRIGHTNESS_RST;
      off_channel_level <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_PATTERN: ticks_per_pattern <= cfg_data;
        CFG_MIN_BRIGHTNESS:    min_brightness    <= cfg_data;
        CFG_OFF_CHANNEL_LEVEL: off_channel_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp level to 255, then raise to the brightness floor
  always_comb begin
    if (s1_level > $signed({{(LEVEL_W-COLOR_W){1'b0}}, BRIGHT_MAX})) begin
      bright = BRIGHT_MAX;
    end else if (s1_level < $signed({{(LEVEL_W-8){1'b0}}, min_brightness})) begin
      bright = min_brightness;
    end else begin
      bright = s1_level[COLOR_W-1:0];
    end
  end

  // Advance state: loud ticks and pattern first, then peak and quiet run
  always_comb begin
    loud_inc           = (bright > LOUD_LEVEL) ? loud_ticks + 8'd1 : loud_ticks;
    loud_ticks_next    = loud_inc;
    pattern_index_next = pattern_index;
    if (loud_inc > ticks_per_pattern) begin
      pattern_index_next = pattern_index + 3'd1;
      loud_ticks_next    = '0;
    end

    peak_max      = (s1_level > peak_level) ? s1_level : peak_level;
    peak_age_next = peak_age + 8'd1;
    peak_level_next = (peak_age_next == 8'd0) ? s1_level : peak_max;

    // level < trunc(peak/5) without a divider:
    //   peak >= 0: 5*level + 5 <= peak ; peak < 0: 5*level < peak
    lvl_x5   = {{2{s1_level[LEVEL_W-1]}}, s1_level, 2'b00}
             + {{4{s1_level[LEVEL_W-1]}}, s1_level};
    peak_ext = {{4{peak_level_next[LEVEL_W-1]}}, peak_level_next};
    if (peak_level_next[LEVEL_W-1]) begin
      quiet = lvl_x5 < peak_ext;
    end else begin
      quiet = (lvl_x5 + 20'sd5) <= peak_ext;
    end

    if (quiet) begin
      quiet_count_next = quiet_count + 8'd1;
    end else begin
      quiet_count_next = '0;
      if (quiet_count > QUIET_RUN_MAX) begin
        pattern_index_next = PAT_FLASH;
      end
    end
  end

  // Map pattern to channel levels
  always_comb begin
    red_next   = off_channel_level;
    green_next = off_channel_level;
    blue_next  = off_channel_level;
    fade_next  = 1'b1;
    unique case (pattern_index_next)
      PAT_BLUE:    blue_next = bright;
      PAT_GREEN:   green_next = bright;
      PAT_RED:     red_next = bright;
      PAT_YELLOW: begin
        red_next   = bright;
        green_next = bright;
      end
      PAT_CYAN: begin
        green_next = bright;
        blue_next  = bright;
      end
      PAT_MAGENTA: begin
        red_next  = bright;
        blue_next = bright;
      end
      default: begin
        red_next   = bright;
        green_next = bright;
        blue_next  = bright;
        fade_next  = 1'b0;
      end
    endcase
  end

  // Hold state and the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      pattern_index <= '0;
      loud_ticks    <= '0;
      peak_level    <= '0;
      peak_age      <= '0;
      quiet_count   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        pattern_index <= pattern_index_next;
        loud_ticks    <= loud_ticks_next;
        peak_level    <= peak_level_next;
        peak_age      <= peak_age_next;
        quiet_count   <= quiet_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level <= level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red     <= red_next;
      green   <= green_next;
      blue    <= blue_next;
      fade    <= fade_next;
      pattern <= pattern_index_next;
    end
  end

  // Solid white patterns are set at once on all three channels
  a_white_no_fade: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pattern == PAT_WHITE || pattern == PAT_FLASH)
      |-> !fade && red == green && green == blue)
    else $error("white pattern with fade or unequal channels");

  // Colored patterns always fade
  a_color_fades: assert property (@(posedge clk) disable iff (rst)
    out_valid && pattern != PAT_WHITE && pattern != PAT_FLASH |-> fade)
    else $error("colored pattern without fade");

  // A pending item moves into a free or draining result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && pattern == $past(pattern_index_next))
    else $error("result register not loaded");

  // Pattern holds, steps by one, or jumps to the forced pattern
  a_pattern_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> pattern_index == $past(pattern_index)
             || pattern_index == $past(pattern_index) + 3'd1
             || pattern_index == PAT_FLASH)
    else $error("pattern index changed unexpectedly");

endmodule
